>>> hdl/additive_sine_sweep_synth_unit_assert.svh
// assertion macros shared by the synthesiser modules
// expects clk and rst to be visible where a macro is used
`ifndef ADDITIVE_SINE_SWEEP_SYNTH_UNIT_ASSERT_SVH
`define ADDITIVE_SINE_SWEEP_SYNTH_UNIT_ASSERT_SVH
// same-cycle implication
`define ASSN_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSN_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hdl/assn_pkg.sv
// shared types, constants and the sine table builder for the sweep synthesiser
// used by assn_div, assn_core and additive_sine_sweep_synth_unit
package assn_pkg;

  localparam int MAX_COMPONENTS_DEF  = 4;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int MAX_BLOCK           = 64;
  localparam int FADE_SAMPLES        = 100;

  localparam int LANE_W    = 12;
  localparam int DIV_NUM_W = 57;
  localparam int DIV_DEN_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam longint ONE_Q30 = 64'sd1 <<< 30;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_COMPONENTS = 3'd0,
    CFG_MULTIPLIERS    = 3'd1,
    CFG_WEIGHTS        = 3'd2,
    CFG_START_STEP     = 3'd3,
    CFG_END_STEP       = 3'd4,
    CFG_START_GAIN     = 3'd5,
    CFG_END_GAIN       = 3'd6,
    CFG_NOTE_LENGTH    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]  num_components;
    logic [47:0] component_multipliers;
    logic [47:0] component_weights;
    logic [31:0] start_step;
    logic [31:0] end_step;
    logic [15:0] start_gain;
    logic [15:0] end_gain;
    logic [23:0] note_length;
  } cfg_t;

  typedef struct packed {
    logic [23:0] start_sample;
    logic [6:0]  sample_count;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               clipped;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP_MUL,
    ST_STEP_GO,
    ST_GAIN_MUL,
    ST_GAIN_GO,
    ST_FIN_GO,
    ST_FOUT_GO,
    ST_DIV_WAIT,
    ST_COMP_INC,
    ST_COMP_PHASE,
    ST_COMP_ACC,
    ST_FADE,
    ST_SCALE,
    ST_ROUND,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    TAG_STEP,
    TAG_GAIN,
    TAG_FIN,
    TAG_FOUT
  } div_tag_t;

  // one quarter-wave entry, q30 taylor series, rounded to q1.15
  function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] t;
    longint      s;
    x = (64'(k) * HALF_PI_Q30) >> qbits;
    t = x;
    s = longint'(x);
    for (int i = 1; i <= 8; i++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / TAYLOR_DIV[i-1];
      if (i % 2 == 1) begin
        s = s - longint'(t);
      end else begin
        s = s + longint'(t);
      end
    end
    if (s < 0) s = 0;
    if (s > ONE_Q30) s = ONE_Q30;
    s = (s + 64'sd16384) >>> 15;
    if (s > 32767) s = 32767;
    return 16'(s);
  endfunction

endpackage

>>> hdl/assn_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on assn_pkg for the request and response structs
`include "additive_sine_sweep_synth_unit_assert.svh"
module assn_div (
  input  logic               clk,
  input  logic               rst,
  input  assn_pkg::div_req_t req,
  output assn_pkg::div_rsp_t rsp
);
  import assn_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 ge;

  assign rem_sh  = {rem, quo[DIV_NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign ge      = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      quo <= {quo[DIV_NUM_W-2:0], ge};
      rem <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

  `ASSN_HOLDS(a_start_idle, req.start, !busy, "divider started while busy")

endmodule

>>> hdl/assn_core.sv
// per-sample sequencer: sweep interpolation, phase accumulators, sine table,
// fades, scaling and the output register; depends on assn_pkg
`include "additive_sine_sweep_synth_unit_assert.svh"
module assn_core #(
  parameter int MAX_COMPONENTS  = assn_pkg::MAX_COMPONENTS_DEF,
  parameter int SINE_TABLE_BITS = assn_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  assn_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  assn_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output assn_pkg::out_item_t out_data,
  output assn_pkg::div_req_t  div_req,
  input  assn_pkg::div_rsp_t  div_rsp
);
  import assn_pkg::*;

  localparam int STB     = SINE_TABLE_BITS;
  localparam int QUARTER = 2 ** (STB - 2);
  localparam int J_W     = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam logic [2:0]     MAXC_L    = 3'(MAX_COMPONENTS);
  localparam logic [6:0]     BLOCK_L   = 7'(MAX_BLOCK);
  localparam logic [23:0]    FADE_L    = 24'(FADE_SAMPLES);
  localparam logic [STB-2:0] QUARTER_L = (STB - 1)'(QUARTER);
  localparam logic [61:0]    ROUND_HALF = 62'(1) << 39;

  logic [15:0] sine_rom [QUARTER + 1];
  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, STB - 2);
  end

  state_t state, state_next;
  div_tag_t div_tag;

  logic [24:0]        n;
  logic [6:0]         rem_cnt;
  logic [J_W-1:0]     j;
  logic [56:0]        mul_prod;
  logic               interp_neg;
  logic [31:0]        step;
  logic [15:0]        gain;
  logic [16:0]        fin;
  logic [16:0]        fout;
  logic [16:0]        fade;
  logic [31:0]        inc;
  logic [31:0]        phase [MAX_COMPONENTS];
  logic signed [29:0] sum;
  logic [44:0]        mag;
  logic               val_neg;
  logic [61:0]        prodr;

  logic [23:0]        len;
  logic               n_lt_len;
  logic [23:0]        m;
  logic [23:0]        fi;
  logic               ramp_on;
  logic               fin_div;
  logic               fout_div;
  logic [2:0]         comps;
  logic               last_comp;
  logic [32:0]        ds;
  logic [32:0]        ds_abs;
  logic [16:0]        dg;
  logic [16:0]        dg_abs;
  logic [LANE_W-1:0]  mult_j;
  logic signed [LANE_W-1:0] weight_j;
  logic [43:0]        inc_full;
  logic [STB-1:0]     idx;
  logic [1:0]         quad;
  logic [STB-2:0]     addr;
  logic [15:0]        sine_mag;
  logic signed [16:0] sine_val;
  logic signed [28:0] wprod;
  logic signed [46:0] val_full;
  logic [33:0]        fade_full;
  logic [61:0]        rsum;
  logic [21:0]        r;
  logic [31:0]        q32;
  logic [15:0]        q16;
  logic [6:0]         count_in;
  logic               can_emit;
  logic               emit_fire;
  out_item_t          out_next;

  assign len      = (cfg.note_length == 24'd0) ? 24'd1 : cfg.note_length;
  assign n_lt_len = n < {1'b0, len};
  assign m        = n_lt_len ? n[23:0] : len;
  assign fi       = (FADE_L > len) ? (len >> 1) : FADE_L;
  assign ramp_on  = fi > 24'd1;
  assign fin_div  = (n < {1'b0, fi}) && ramp_on;
  assign fout_div = n_lt_len && (n[23:0] >= len - fi) && ramp_on;
  assign comps    = (cfg.num_components > MAXC_L) ? MAXC_L : cfg.num_components;
  assign last_comp = (3'(j) + 3'd1) == comps;

  assign ds     = {1'b0, cfg.end_step} - {1'b0, cfg.start_step};
  assign ds_abs = ds[32] ? -ds : ds;
  assign dg     = {1'b0, cfg.end_gain} - {1'b0, cfg.start_gain};
  assign dg_abs = dg[16] ? -dg : dg;

  assign mult_j   = cfg.component_multipliers[j * LANE_W +: LANE_W];
  assign weight_j = $signed(cfg.component_weights[j * LANE_W +: LANE_W]);
  assign inc_full = step * mult_j;

  assign idx      = phase[j][31 -: STB];
  assign quad     = idx[STB-1 -: 2];
  assign addr     = quad[0] ? (QUARTER_L - {1'b0, idx[STB-3:0]}) : {1'b0, idx[STB-3:0]};
  assign sine_mag = sine_rom[addr];
  assign sine_val = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
  assign wprod    = weight_j * sine_val;

  assign val_full  = sum * $signed({1'b0, gain});
  assign fade_full = fin * fout;
  assign rsum      = prodr + ROUND_HALF;
  assign r         = rsum[61:40];

  assign q32 = div_rsp.quot[31:0];
  assign q16 = div_rsp.quot[15:0];
  assign count_in = (in_data.sample_count > BLOCK_L) ? BLOCK_L : in_data.sample_count;

  assign can_emit  = !out_valid || !out_stall;
  assign emit_fire = (state == ST_EMIT) && can_emit;

  always_comb begin
    out_next.last = rem_cnt == 7'd1;
    if (val_neg) begin
      out_next.clipped      = r > 22'd32768;
      out_next.sample_value = out_next.clipped ? 16'sh8000 : $signed(-r[15:0]);
    end else begin
      out_next.clipped      = r > 22'd32767;
      out_next.sample_value = out_next.clipped ? 16'sh7fff : $signed(r[15:0]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = (count_in == 7'd0) ? ST_IDLE : ST_STEP_MUL;
      end
      ST_STEP_MUL:  state_next = ST_STEP_GO;
      ST_STEP_GO:   state_next = ST_DIV_WAIT;
      ST_GAIN_MUL:  state_next = ST_GAIN_GO;
      ST_GAIN_GO:   state_next = ST_DIV_WAIT;
      ST_FIN_GO:    state_next = fin_div ? ST_DIV_WAIT : ST_FOUT_GO;
      ST_FOUT_GO: begin
        if (fout_div) begin
          state_next = ST_DIV_WAIT;
        end else begin
          state_next = (comps == 3'd0) ? ST_FADE : ST_COMP_INC;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          unique case (div_tag)
            TAG_STEP: state_next = ST_GAIN_MUL;
            TAG_GAIN: state_next = ST_FIN_GO;
            TAG_FIN:  state_next = ST_FOUT_GO;
            TAG_FOUT: state_next = (comps == 3'd0) ? ST_FADE : ST_COMP_INC;
          endcase
        end
      end
      ST_COMP_INC:   state_next = ST_COMP_PHASE;
      ST_COMP_PHASE: state_next = ST_COMP_ACC;
      ST_COMP_ACC:   state_next = last_comp ? ST_FADE : ST_COMP_INC;
      ST_FADE:       state_next = ST_SCALE;
      ST_SCALE:      state_next = ST_ROUND;
      ST_ROUND:      state_next = ST_EMIT;
      ST_EMIT: begin
        if (can_emit) state_next = out_next.last ? ST_IDLE : ST_STEP_MUL;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = rst || (state != ST_IDLE);
    div_req  = '0;
    unique case (state)
      ST_STEP_GO, ST_GAIN_GO: begin
        div_req.start = 1'b1;
        div_req.num   = mul_prod;
        div_req.den   = len;
      end
      ST_FIN_GO: begin
        div_req.start = fin_div;
        div_req.num   = 57'({n, 16'h0000});
        div_req.den   = fi - 24'd1;
      end
      ST_FOUT_GO: begin
        div_req.start = fout_div;
        div_req.num   = 57'({len - n[23:0] - 24'd1, 16'h0000});
        div_req.den   = fi - 24'd1;
      end
      default: div_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_tag <= TAG_STEP;
      rem_cnt <= '0;
      j       <= '0;
      for (int k = 0; k < MAX_COMPONENTS; k++) phase[k] <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            n       <= {1'b0, in_data.start_sample};
            rem_cnt <= count_in;
            if (in_data.start_sample == 24'd0) begin
              for (int k = 0; k < MAX_COMPONENTS; k++) phase[k] <= '0;
            end
          end
        end
        ST_STEP_MUL: begin
          mul_prod   <= ds_abs * m;
          interp_neg <= ds[32];
          j          <= '0;
          sum        <= '0;
        end
        ST_STEP_GO: div_tag <= TAG_STEP;
        ST_GAIN_MUL: begin
          mul_prod   <= 57'(dg_abs) * 57'(m);
          interp_neg <= dg[16];
        end
        ST_GAIN_GO: div_tag <= TAG_GAIN;
        ST_FIN_GO: begin
          div_tag <= TAG_FIN;
          if (!fin_div) fin <= 17'h10000;
        end
        ST_FOUT_GO: begin
          div_tag <= TAG_FOUT;
          if (!n_lt_len) begin
            fout <= '0;
          end else if (!fout_div) begin
            fout <= 17'h10000;
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            unique case (div_tag)
              TAG_STEP: step <= cfg.start_step + (interp_neg ? -q32 : q32);
              TAG_GAIN: gain <= cfg.start_gain + (interp_neg ? -q16 : q16);
              TAG_FIN:  fin  <= div_rsp.quot[16:0];
              TAG_FOUT: fout <= div_rsp.quot[16:0];
            endcase
          end
        end
        ST_COMP_INC:   inc <= inc_full[39:8];
        ST_COMP_PHASE: phase[j] <= phase[j] + inc;
        ST_COMP_ACC: begin
          sum <= sum + 30'(wprod);
          j   <= j + J_W'(1);
        end
        ST_FADE: fade <= fade_full[32:16];
        ST_SCALE: begin
          val_neg <= val_full[46];
          mag     <= val_full[46] ? 45'(-val_full) : 45'(val_full);
        end
        ST_ROUND: prodr <= mag * fade;
        ST_EMIT: begin
          if (can_emit) begin
            n       <= n + 25'd1;
            rem_cnt <= rem_cnt - 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) out_data <= out_next;
  end

  `ASSN_HOLDS(a_div_done_wait, div_rsp.done, state == ST_DIV_WAIT, "divider result outside wait")
  `ASSN_HOLDS(a_comp_range, state == ST_COMP_INC, (3'(j) < comps), "component index past count")
  `ASSN_NEXT(a_last_idle, emit_fire && out_next.last, state == ST_IDLE, "no return to idle")
  `ASSN_NEXT(a_emit_wait, (state == ST_EMIT) && !emit_fire, out_valid && (state == ST_EMIT), "emit held wrongly")

endmodule

>>> hdl/additive_sine_sweep_synth_unit.sv
// a request is taken only in idle; its samples are computed one at a time and the next
// request waits until the last beat is emitted; output stalls hold the sequencer; the
// shared 57-bit serial divider runs twice per sample and once more inside either fade ramp
// reset: synchronous, clears sequencer, phases and registers to defaults
// config regs, core sequencer and the shared divider; depends on assn_pkg
module additive_sine_sweep_synth_unit #(
  parameter int MAX_COMPONENTS  = assn_pkg::MAX_COMPONENTS_DEF,
  parameter int SINE_TABLE_BITS = assn_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [assn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [assn_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  assn_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output assn_pkg::out_item_t                 out_data
);
  import assn_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_components        <= 3'd1;
      cfg.component_multipliers <= 48'd256;
      cfg.component_weights     <= 48'd1024;
      cfg.start_step            <= '0;
      cfg.end_step              <= '0;
      cfg.start_gain            <= 16'd16384;
      cfg.end_gain              <= 16'd16384;
      cfg.note_length           <= 24'd48000;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_NUM_COMPONENTS: cfg.num_components        <= cfg_data[2:0];
        CFG_MULTIPLIERS:    cfg.component_multipliers <= cfg_data;
        CFG_WEIGHTS:        cfg.component_weights     <= cfg_data;
        CFG_START_STEP:     cfg.start_step            <= cfg_data[31:0];
        CFG_END_STEP:       cfg.end_step              <= cfg_data[31:0];
        CFG_START_GAIN:     cfg.start_gain            <= cfg_data[15:0];
        CFG_END_GAIN:       cfg.end_gain              <= cfg_data[15:0];
        CFG_NOTE_LENGTH:    cfg.note_length           <= cfg_data[23:0];
      endcase
    end
  end

  assn_core #(
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

  assn_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

endmodule

>>> tb/tb_additive_sine_sweep_synth_unit.sv
// self-checking testbench for the additive sine sweep synthesiser
// predicts every sample with its own fixed-point sweep model, checks each beat in order
// depends on assn_pkg and additive_sine_sweep_synth_unit
module tb_additive_sine_sweep_synth_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import assn_pkg::*;

  localparam int QTR = 256;
  localparam int SETTLE = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  additive_sine_sweep_synth_unit u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // voice settings and oscillator state as the predictor sees them
  logic [2:0]  voices;
  logic [47:0] lane_mult;
  logic [47:0] lane_weight;
  logic [31:0] step_lo, step_hi;
  logic [15:0] gain_lo, gain_hi;
  logic [23:0] note_len;
  logic [31:0] osc_phase [4];
  logic [15:0] quarter_sine [QTR+1];

  out_item_t pending_samples [$];
  int mismatches = 0;
  int requests = 0;
  int samples_seen = 0;
  int clipped_seen = 0;
  bit idling = 1'b1;
  int hold_asked = 0;

  function automatic void fill_quarter_sine();
    longint unsigned x, t;
    longint s;
    for (int k = 0; k <= QTR; k++) begin
      x = (longint'(k) * 64'd1686629713) / QTR;
      t = x;
      s = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) s = s - longint'(t);
        else s = s + longint'(t);
      end
      if (s < 0) s = 0;
      if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
      s = (s + 16384) >>> 15;
      if (s > 32767) s = 32767;
      quarter_sine[k] = 16'(s);
    end
  endfunction

  function automatic longint sine_at(logic [31:0] ph);
    logic [9:0] idx;
    longint v;
    idx = ph[31:22];
    v = idx[8] ? longint'(quarter_sine[QTR - idx[7:0]]) : longint'(quarter_sine[idx[7:0]]);
    return idx[9] ? -v : v;
  endfunction

  function automatic longint sweep(longint a, longint b, longint m, longint len);
    return a + ((b - a) * m) / len;
  endfunction

  function automatic void synthesise_request(in_item_t req);
    longint len, comps, cnt, fi, fo, n, m, step, gain, fin, fout, fade, sum, val, w;
    longint unsigned mag;
    logic [11:0] lw;
    out_item_t s;
    len = (note_len == 0) ? 1 : longint'(note_len);
    comps = (voices > 4) ? 4 : longint'(voices);
    cnt = (req.sample_count > MAX_BLOCK) ? MAX_BLOCK : longint'(req.sample_count);
    if (req.start_sample == 0) for (int j = 0; j < 4; j++) osc_phase[j] = '0;
    fi = (FADE_SAMPLES > len) ? len / 2 : FADE_SAMPLES;
    fo = fi;
    for (longint i = 0; i < cnt; i++) begin
      n = longint'(req.start_sample) + i;
      m = (n < len) ? n : len;
      step = sweep(longint'(step_lo), longint'(step_hi), m, len) & 64'hFFFF_FFFF;
      gain = sweep(longint'(gain_lo), longint'(gain_hi), m, len);
      sum = 0;
      for (int j = 0; j < comps; j++) begin
        lw = lane_weight[12*j +: 12];
        w = longint'($signed(lw));
        osc_phase[j] = osc_phase[j] + 32'((step * longint'(lane_mult[12*j +: 12])) >> 8);
        sum += w * sine_at(osc_phase[j]);
      end
      fin = 65536;
      fout = 65536;
      if (n < fi && fi > 1) fin = (n << 16) / (fi - 1);
      if (n >= len) fout = 0;
      else if (n >= len - fo && fo > 1) fout = ((len - n - 1) << 16) / (fo - 1);
      fade = (fin * fout) >> 16;
      val = sum * gain;
      mag = (val < 0) ? longint'(-val) : longint'(val);
      mag = (mag * longint'(fade) + (64'd1 << 39)) >> 40;
      s.clipped = 1'b0;
      if (val < 0) begin
        if (mag > 32768) begin mag = 32768; s.clipped = 1'b1; end
        s.sample_value = 16'(-longint'(mag));
      end else begin
        if (mag > 32767) begin mag = 32767; s.clipped = 1'b1; end
        s.sample_value = 16'(mag);
      end
      s.last = (i + 1 == cnt);
      pending_samples.push_back(s);
    end
  endfunction

  // receive side: checks each beat, random stall bursts, long hold on request
  int stall_left = 0;
  int run_left = 0;
  int hold_done = 0;
  int hold_left = 0;
  out_item_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        samples_seen++;
        if (out_data.clipped) clipped_seen++;
        if (pending_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %p", out_data);
        end else begin
          want = pending_samples.pop_front();
          if (want !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat mismatch: exp value %0d clip %0b last %0b, got %0d %0b %0b",
                       want.sample_value, want.clipped, want.last,
                       out_data.sample_value, out_data.clipped, out_data.last);
          end
        end
      end
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!idling) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        run_left = $urandom_range(1, 40);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(logic [23:0] first, logic [6:0] cnt);
    in_item_t req;
    req.start_sample = first;
    req.sample_count = cnt;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    requests++;
    synthesise_request(req);
  endtask

  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // registers change only once every request has been answered
  task automatic write_reg(cfg_reg_e idx, logic [47:0] value);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_NUM_COMPONENTS: voices = value[2:0];
      CFG_MULTIPLIERS:    lane_mult = value;
      CFG_WEIGHTS:        lane_weight = value;
      CFG_START_STEP:     step_lo = value[31:0];
      CFG_END_STEP:       step_hi = value[31:0];
      CFG_START_GAIN:     gain_lo = value[15:0];
      CFG_END_GAIN:       gain_hi = value[15:0];
      default:            note_len = value[23:0];
    endcase
  endtask

  task automatic set_voice(logic [2:0] nv, logic [47:0] mult, logic [47:0] wt,
                           logic [31:0] s0, logic [31:0] s1, logic [15:0] g0,
                           logic [15:0] g1, logic [23:0] len);
    write_reg(CFG_NUM_COMPONENTS, 48'(nv));
    write_reg(CFG_MULTIPLIERS, mult);
    write_reg(CFG_WEIGHTS, wt);
    write_reg(CFG_START_STEP, 48'(s0));
    write_reg(CFG_END_STEP, 48'(s1));
    write_reg(CFG_START_GAIN, 48'(g0));
    write_reg(CFG_END_GAIN, 48'(g1));
    write_reg(CFG_NOTE_LENGTH, 48'(len));
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // reset defaults, then field extremes, zero and large counts
  task automatic test_defaults_and_extremes();
    send_request(24'd0, 7'd3);
    send_request(24'd3, 7'd1);
    send_request(24'd0, 7'd0);
    send_request(24'hFFFFFF, 7'd2);
    send_request(24'd47990, 7'd20);
    send_request(24'd0, 7'd127);
    drain();
  endtask

  // short note: fade-in, fade-out, past the end, loud sum that saturates
  task automatic test_fades_and_clipping();
    set_voice(3'd4, 48'hFFF_800_100_001, 48'h7FF_7FF_7FF_7FF, 32'h0100_0000,
              32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 24'd150);
    send_request(24'd0, 7'd64);
    send_request(24'd64, 7'd64);
    send_request(24'd128, 7'd40);
    set_voice(3'd4, 48'h100_100_100_100, 48'h800_800_800_800, 32'h0400_0000,
              32'h0400_0000, 16'hFFFF, 16'hFFFF, 24'd16777215);
    send_request(24'd200, 7'd4);
    drain();
  endtask

  // tiny and zero note lengths, silent and over-range component counts
  task automatic test_short_notes();
    set_voice(3'd0, 48'hFFF_FFF_FFF_FFF, 48'h400_400_400_400, 32'hFFFF_FFFF,
              32'h0, 16'h4000, 16'h4000, 24'd0);
    send_request(24'd0, 7'd2);
    write_reg(CFG_NUM_COMPONENTS, 48'd7);
    send_request(24'd0, 7'd3);
    write_reg(CFG_NOTE_LENGTH, 48'd1);
    send_request(24'd0, 7'd3);
    write_reg(CFG_NOTE_LENGTH, 48'd3);
    send_request(24'd0, 7'd5);
    write_reg(CFG_NUM_COMPONENTS, 48'd2);
    send_request(24'd1, 7'd4);
    drain();
  endtask

  task automatic random_phase(int items, int len_max);
    logic [23:0] nxt;
    logic [6:0] cnt;
    set_voice(3'($urandom_range(0, 7)), rand48(), rand48(), $urandom, $urandom,
              16'($urandom), 16'($urandom), 24'($urandom_range(1, len_max)));
    nxt = 24'd0;
    cnt = 7'd1;
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          cnt = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(64, 127))
                                             : 7'($urandom_range(0, 8));
          nxt = 24'($urandom);
        end
        1: nxt = 24'd0;
        default: cnt = 7'($urandom_range(1, 8));
      endcase
      if ($urandom_range(0, 24) == 0) cnt = 7'd64;
      send_request(nxt, cnt);
      nxt = nxt + 24'((cnt > 64) ? 64 : cnt);
    end
    drain();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_long_hold();
    @(posedge clk);
    hold_asked++;
    for (int i = 0; i < 6; i++) send_request(24'(i * 8), 7'd8);
    drain();
  endtask

  initial begin
    fill_quarter_sine();
    voices = 3'd1;
    lane_mult = 48'd256;
    lane_weight = 48'd1024;
    step_lo = '0;
    step_hi = '0;
    gain_lo = 16'd16384;
    gain_hi = 16'd16384;
    note_len = 24'd48000;
    for (int j = 0; j < 4; j++) osc_phase[j] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_defaults_and_extremes();
    test_fades_and_clipping();
    test_short_notes();
    random_phase(40, 300);
    test_long_hold();
    random_phase(40, 2000);
    random_phase(40, 250);
    random_phase(30, 16777215);
    idling = 1'b0;
    random_phase(40, 400);
    $display("%0d requests, %0d samples checked (%0d saturated), %0d still pending",
             requests, samples_seen, clipped_seen, pending_samples.size());
    $display("covered fades, past-end silence, phase reset, saturation and back-pressure");
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("additive_sine_sweep_synth_unit verification clean");
    end else begin
      $display("additive_sine_sweep_synth_unit verification failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("additive_sine_sweep_synth_unit verification failed");
    $finish;
  end

endmodule
